/* hdl/lldc_pkg.sv */
`timescale 1ns / 1ps
package lldc_pkg;

    localparam int MAX_SHIFT_LIMIT_DEF = 16;
    localparam int COUNT_BITS_DEF      = 16;
    localparam int QUEUE_DEPTH         = 4;

    localparam int SHIFT_W = 5;
    localparam int TOTAL_W = 6;
    localparam int BITS_W  = 6;
    localparam int IDX_W   = 2;
    localparam int DATA_W  = 31;

    localparam logic [IDX_W-1:0] CFG_BASE_SHIFT = 2'd0;
    localparam logic [IDX_W-1:0] CFG_HALF_PI    = 2'd1;
    localparam logic [IDX_W-1:0] CFG_ONE        = 2'd2;

    localparam logic KIND_DELTA  = 1'b0;
    localparam logic KIND_HEADER = 1'b1;

    localparam logic [29:0] HALF_PI_RESET = 30'd536870912;
    localparam logic [30:0] ONE_RESET     = 31'd1073741824;

    typedef struct packed {
        logic [4:0]  base_shift;
        logic [29:0] half_pi;
        logic [30:0] one;
    } t_cfg;

    typedef struct packed {
        logic signed [31:0] rx;
        logic signed [31:0] ry;
        logic               fin;
        logic               first;
    } t_point;

    function automatic logic [31:0] clear_low(input logic signed [31:0] z,
                                              input logic [4:0] s);
        logic [32:0] mag;
        logic [32:0] rnd;
        logic [32:0] sum;
        logic [32:0] res;
        if (s == 5'd0) begin
            return z;
        end
        mag = z[31] ? (33'd0 - {z[31], z}) : {1'b0, z};
        rnd = 33'd1 << (s - 5'd1);
        sum = (mag + rnd) & (~33'd0 << s);
        res = z[31] ? (33'd0 - sum) : sum;
        return res[31:0];
    endfunction

endpackage

/* hdl/lldc_front.sv */
`timescale 1ns / 1ps
module lldc_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  lldc_pkg::t_cfg      i_cfg,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic signed [31:0]  i_lon,
    input  logic signed [31:0]  i_lat,
    input  logic                i_last_point,
    output logic                o_push,
    output lldc_pkg::t_point    o_point,
    input  logic                i_full
);
    import lldc_pkg::*;

    localparam logic [2:0] F_IDLE = 3'd0;
    localparam logic [2:0] F_CLS  = 3'd1;
    localparam logic [2:0] F_DIV  = 3'd2;
    localparam logic [2:0] F_FIX  = 3'd3;
    localparam logic [2:0] F_PUSH = 3'd4;

    logic [2:0]         r_state, n_state;
    logic               r_started;
    logic signed [31:0] r_prev_lon;
    logic signed [31:0] r_lon;
    logic signed [31:0] r_lat;
    logic               r_fin;
    logic               r_first;
    logic [31:0]        r_div;
    logic [31:0]        r_rem;
    logic [4:0]         r_cnt;
    logic               r_neg;

    logic signed [33:0] pi34, two_pi34, lon34, t34, u34, d34, unwrap34, fix34;
    logic [31:0]        two_pi32;
    logic [32:0]        rem_sh, rem_sub;
    logic               rem_ge, h_nz;

    always_comb begin
        h_nz     = (i_cfg.half_pi != 30'd0);
        pi34     = $signed({3'b000, i_cfg.half_pi, 1'b0});
        two_pi34 = $signed({2'b00, i_cfg.half_pi, 2'b00});
        two_pi32 = {i_cfg.half_pi, 2'b00};
        lon34    = {{2{r_lon[31]}}, r_lon};
        t34      = lon34 - pi34 - 34'sd1;
        u34      = ~lon34 - pi34;
        d34      = lon34 - {{2{r_prev_lon[31]}}, r_prev_lon};
        if (h_nz && d34 > pi34) begin
            unwrap34 = lon34 - two_pi34;
        end else if (h_nz && d34 < -pi34) begin
            unwrap34 = lon34 + two_pi34;
        end else begin
            unwrap34 = lon34;
        end
        rem_sh  = {r_rem, r_div[31]};
        rem_ge  = rem_sh >= {1'b0, two_pi32};
        rem_sub = rem_sh - {1'b0, two_pi32};
        if (r_neg) begin
            fix34 = pi34 - 34'sd1 - $signed({2'b00, r_rem});
        end else begin
            fix34 = $signed({2'b00, r_rem}) + 34'sd1 - pi34;
        end
    end

    assign o_ready       = (r_state == F_IDLE);
    assign o_push        = (r_state == F_PUSH) && !i_full;
    assign o_point.rx    = clear_low(r_lon, i_cfg.base_shift);
    assign o_point.ry    = clear_low(r_lat, i_cfg.base_shift);
    assign o_point.fin   = r_fin;
    assign o_point.first = r_first;

    always_comb begin
        n_state = r_state;
        case (r_state)
            F_IDLE: if (i_valid) n_state = F_CLS;
            F_CLS: begin
                if (r_first && h_nz && (lon34 > pi34 || lon34 < -pi34)) begin
                    n_state = F_DIV;
                end else begin
                    n_state = F_PUSH;
                end
            end
            F_DIV:  if (r_cnt == 5'd31) n_state = F_FIX;
            F_FIX:  n_state = F_PUSH;
            F_PUSH: if (!i_full) n_state = F_IDLE;
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= F_IDLE;
            r_started <= 1'b0;
        end else begin
            r_state <= n_state;
            case (r_state)
                F_CLS: begin
                    if (n_state == F_PUSH) begin
                        r_started <= !r_fin;
                    end
                end
                F_FIX: r_started <= !r_fin;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            F_IDLE: begin
                if (i_valid) begin
                    r_lon   <= i_lon;
                    r_lat   <= i_lat;
                    r_fin   <= i_last_point;
                    r_first <= !r_started;
                end
            end
            F_CLS: begin
                r_rem <= 32'd0;
                r_cnt <= 5'd0;
                if (r_first && h_nz && lon34 > pi34) begin
                    r_div <= t34[31:0];
                    r_neg <= 1'b0;
                end else if (r_first && h_nz && lon34 < -pi34) begin
                    r_div <= u34[31:0];
                    r_neg <= 1'b1;
                end else if (r_first) begin
                    r_prev_lon <= r_lon;
                end else begin
                    r_lon      <= unwrap34[31:0];
                    r_prev_lon <= unwrap34[31:0];
                end
            end
            F_DIV: begin
                r_rem <= rem_ge ? rem_sub[31:0] : rem_sh[31:0];
                r_div <= {r_div[30:0], 1'b0};
                r_cnt <= r_cnt + 5'd1;
            end
            F_FIX: begin
                r_lon      <= fix34[31:0];
                r_prev_lon <= fix34[31:0];
            end
            default: ;
        endcase
    end

endmodule

/* hdl/lldc_queue.sv */
`timescale 1ns / 1ps
module lldc_queue #(
    parameter int DEPTH = lldc_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  lldc_pkg::t_point i_data,
    output logic             o_full,
    input  logic             i_pop,
    output lldc_pkg::t_point o_data,
    output logic             o_empty
);
    import lldc_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_point           r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            if (i_pop)  r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_data;
    end

endmodule

/* hdl/lldc_back.sv */
`timescale 1ns / 1ps
module lldc_back #(
    parameter int MAX_SHIFT_LIMIT = lldc_pkg::MAX_SHIFT_LIMIT_DEF,
    parameter int COUNT_BITS      = lldc_pkg::COUNT_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  lldc_pkg::t_cfg      i_cfg,
    input  lldc_pkg::t_point    i_point,
    input  logic                i_empty,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_ready,
    output logic                o_kind,
    output logic signed [32:0]  o_dx,
    output logic signed [32:0]  o_dy,
    output logic signed [31:0]  o_lon_min,
    output logic signed [31:0]  o_lon_max,
    output logic signed [31:0]  o_lat_min,
    output logic signed [31:0]  o_lat_max,
    output logic [7:0]          o_control_word,
    output logic [15:0]         o_point_count,
    output logic [31:0]         o_location,
    output logic                o_last
);
    import lldc_pkg::*;

    localparam logic [SHIFT_W-1:0] MAX_SH = MAX_SHIFT_LIMIT[SHIFT_W-1:0];

    localparam logic [2:0] B_LOAD  = 3'd0;
    localparam logic [2:0] B_SEC   = 3'd1;
    localparam logic [2:0] B_CALC  = 3'd2;
    localparam logic [2:0] B_UPD   = 3'd3;
    localparam logic [2:0] B_DELTA = 3'd4;
    localparam logic [2:0] B_HDR   = 3'd5;

    function automatic logic [47:0] round_shift(input logic [47:0] v,
                                                input logic [TOTAL_W-1:0] s);
        logic [48:0] mag;
        logic [48:0] t;
        logic [48:0] res;
        if (s == '0) begin
            return v;
        end
        mag = v[47] ? (49'd0 - {v[47], v}) : {1'b0, v};
        t   = mag >> (s - TOTAL_W'(1));
        res = (t + 49'd1) >> 1;
        return v[47] ? (48'd0 - res[47:0]) : res[47:0];
    endfunction

    function automatic logic [BITS_W-1:0] sbits(input logic [32:0] v);
        logic [32:0]       u;
        logic [BITS_W-1:0] n;
        u = v[32] ? ~v : v;
        n = '0;
        for (int i = 0; i < 33; i++) begin
            if (u[i]) n = BITS_W'(i + 1);
        end
        return n + BITS_W'(1);
    endfunction

    logic [2:0]             r_state;
    t_point                 r_pt;
    logic [29:0]            r_d;
    logic [30:0]            r_num;
    logic [SHIFT_W-1:0]     r_sh;
    logic signed [32:0]     r_x1;
    logic [47:0]            r_x0;
    logic signed [32:0]     r_dx;
    logic signed [32:0]     r_dy;
    logic signed [TOTAL_W-1:0] r_ns;
    logic [47:0]            r_prev_scaled;
    logic signed [31:0]     r_prev_lat;
    logic [SHIFT_W-1:0]     r_prev_s;
    logic signed [31:0]     r_base_lon, r_base_lat;
    logic signed [31:0]     r_lon_low, r_lon_high, r_lat_low, r_lat_high;
    logic [BITS_W-1:0]      r_max_bits;
    logic [COUNT_BITS-1:0]  r_count;
    logic [31:0]            r_loc;

    logic [31:0]            abs_ry;
    logic signed [32:0]     d33;
    logic [32:0]            neg_d;
    logic signed [TOTAL_W-1:0] ns;
    logic [SHIFT_W-1:0]     s_use;
    logic [TOTAL_W-1:0]     total;
    logic [SHIFT_W-1:0]     ns_left;
    logic signed [32:0]     diff_lat;
    logic [47:0]            x1_rs;
    logic [47:0]            x1_48;
    logic [47:0]            dx48;
    logic [BITS_W-1:0]      bx, by, bmax;
    logic [2:0]             len_m1, len;
    logic [31:0]            loc_add;
    logic                   out_free;

    always_comb begin
        abs_ry   = i_point.ry[31] ? (32'd0 - i_point.ry) : i_point.ry;
        d33      = $signed({3'b000, i_cfg.half_pi}) - $signed({1'b0, abs_ry});
        neg_d    = 33'd0 - d33;
        ns       = $signed({1'b0, r_sh}) - $signed({1'b0, r_prev_s});
        s_use    = (!r_pt.first && ns > 0) ? r_prev_s : r_sh;
        total    = TOTAL_W'(i_cfg.base_shift) + TOTAL_W'(s_use);
        ns_left  = SHIFT_W'(-ns);
        diff_lat = {r_pt.ry[31], r_pt.ry} - {r_prev_lat[31], r_prev_lat};
        x1_rs    = round_shift({{16{r_pt.rx[31]}}, r_pt.rx}, total);
        x1_48    = {{15{r_x1[32]}}, r_x1};
        dx48     = x1_48 - r_x0;
        bx       = sbits(dx48[32:0]);
        by       = sbits(r_dy);
        bmax     = (by > bx) ? by : bx;
        len_m1   = (r_max_bits == '0) ? 3'd0 : 3'((r_max_bits - BITS_W'(1)) >> 3);
        len      = len_m1 + 3'd1;
        loc_add  = (32'(r_count) * 32'(len)) << 1;
        out_free = !o_valid || i_ready;
    end

    assign o_pop = (r_state == B_LOAD) && !i_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_LOAD;
            o_valid <= 1'b0;
        end else begin
            if ((r_state == B_DELTA || r_state == B_HDR) && out_free) begin
                o_valid <= 1'b1;
            end else if (i_ready) begin
                o_valid <= 1'b0;
            end
            case (r_state)
                B_LOAD: begin
                    if (!i_empty) begin
                        r_state <= (d33 > 0) ? B_SEC : B_CALC;
                    end
                end
                B_SEC: begin
                    if (!(r_sh < MAX_SH && {1'b0, r_d} <= r_num)) r_state <= B_CALC;
                end
                B_CALC: r_state <= B_UPD;
                B_UPD: begin
                    if (!r_pt.first) begin
                        r_state <= B_DELTA;
                    end else if (r_pt.fin) begin
                        r_state <= B_HDR;
                    end else begin
                        r_state <= B_LOAD;
                    end
                end
                B_DELTA: begin
                    if (out_free) begin
                        r_state <= r_pt.fin ? B_HDR : B_LOAD;
                    end
                end
                B_HDR: begin
                    if (out_free) begin
                        r_state <= B_LOAD;
                    end
                end
                default: r_state <= B_LOAD;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_scaled <= '0;
            r_prev_lat    <= '0;
            r_prev_s      <= '0;
            r_base_lon    <= '0;
            r_base_lat    <= '0;
            r_lon_low     <= '0;
            r_lon_high    <= '0;
            r_lat_low     <= '0;
            r_lat_high    <= '0;
            r_max_bits    <= '0;
            r_count       <= '0;
            r_loc         <= '0;
        end else begin
            case (r_state)
                B_UPD: begin
                    r_prev_lat <= r_pt.ry;
                    r_prev_s   <= r_sh;
                    if (r_pt.first) begin
                        r_base_lon    <= r_pt.rx;
                        r_base_lat    <= r_pt.ry;
                        r_lon_low     <= r_pt.rx;
                        r_lon_high    <= r_pt.rx;
                        r_lat_low     <= r_pt.ry;
                        r_lat_high    <= r_pt.ry;
                        r_prev_scaled <= x1_48;
                    end else begin
                        if (r_pt.rx < r_lon_low)  r_lon_low  <= r_pt.rx;
                        if (r_pt.rx > r_lon_high) r_lon_high <= r_pt.rx;
                        if (r_pt.ry < r_lat_low)  r_lat_low  <= r_pt.ry;
                        if (r_pt.ry > r_lat_high) r_lat_high <= r_pt.ry;
                        r_prev_scaled <= (r_ns > 0) ?
                            round_shift(x1_48, TOTAL_W'(r_ns)) : x1_48;
                        if (bmax > r_max_bits) r_max_bits <= bmax;
                        if (r_count != '1) r_count <= r_count + COUNT_BITS'(1);
                    end
                end
                B_HDR: begin
                    if (out_free) begin
                        r_loc         <= r_loc + loc_add;
                        r_prev_scaled <= '0;
                        r_prev_lat    <= '0;
                        r_prev_s      <= '0;
                        r_base_lon    <= '0;
                        r_base_lat    <= '0;
                        r_lon_low     <= '0;
                        r_lon_high    <= '0;
                        r_lat_low     <= '0;
                        r_lat_high    <= '0;
                        r_max_bits    <= '0;
                        r_count       <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            B_LOAD: begin
                if (!i_empty) begin
                    r_pt  <= i_point;
                    r_d   <= d33[29:0];
                    r_num <= i_cfg.one >> 1;
                    if (d33 == 0) begin
                        r_sh <= MAX_SH;
                    end else if (d33 < 0) begin
                        r_sh <= ({2'b00, i_cfg.one} >= neg_d) ? MAX_SH : '0;
                    end else begin
                        r_sh <= '0;
                    end
                end
            end
            B_SEC: begin
                if (r_sh < MAX_SH && {1'b0, r_d} <= r_num) begin
                    r_sh  <= r_sh + SHIFT_W'(1);
                    r_num <= r_num >> 1;
                end
            end
            B_CALC: begin
                r_x1 <= x1_rs[32:0];
                r_x0 <= (ns < 0) ? (r_prev_scaled << ns_left) : r_prev_scaled;
                r_ns <= ns;
                r_dy <= diff_lat >>> i_cfg.base_shift;
            end
            B_UPD: r_dx <= dx48[32:0];
            B_DELTA: begin
                if (out_free) begin
                    o_kind         <= KIND_DELTA;
                    o_dx           <= r_dx;
                    o_dy           <= r_dy;
                    o_lon_min      <= '0;
                    o_lon_max      <= '0;
                    o_lat_min      <= '0;
                    o_lat_max      <= '0;
                    o_control_word <= '0;
                    o_point_count  <= '0;
                    o_location     <= '0;
                    o_last         <= !r_pt.fin;
                end
            end
            B_HDR: begin
                if (out_free) begin
                    o_kind         <= KIND_HEADER;
                    o_dx           <= {r_base_lon[31], r_base_lon};
                    o_dy           <= {r_base_lat[31], r_base_lat};
                    o_lon_min      <= r_lon_low;
                    o_lon_max      <= r_lon_high;
                    o_lat_min      <= r_lat_low;
                    o_lat_max      <= r_lat_high;
                    o_control_word <= {len_m1, i_cfg.base_shift};
                    o_point_count  <= 16'(r_count);
                    o_location     <= r_loc;
                    o_last         <= 1'b1;
                end
            end
            default: ;
        endcase
    end

endmodule

/* hdl/lonlat_delta_compressor_core.sv */
`timescale 1ns / 1ps
// Polyline point delta compressor. The front end classifies each point and pushes
// it into the queue; on the first point of a polyline whose longitude needs wrapping
// it first runs a remainder divider (one remainder bit per cycle) and a fix-up step.
// The back end loads, calculates and updates each point, with a secant shift search
// (one compare per cycle) when the latitude lies inside the poles, then sends delta
// and header beats, which output stalls can hold; a 4-entry queue between the two
// halves lets each stall on its own.
module lonlat_delta_compressor_core #(
    parameter int MAX_SHIFT_LIMIT = lldc_pkg::MAX_SHIFT_LIMIT_DEF,
    parameter int COUNT_BITS      = lldc_pkg::COUNT_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [lldc_pkg::IDX_W-1:0]    i_cfg_idx,
    input  logic [lldc_pkg::DATA_W-1:0]   i_cfg_wr_data,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [31:0]            i_lon,
    input  logic signed [31:0]            i_lat,
    input  logic                          i_last_point,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_kind,
    output logic signed [32:0]            o_dx,
    output logic signed [32:0]            o_dy,
    output logic signed [31:0]            o_lon_min,
    output logic signed [31:0]            o_lon_max,
    output logic signed [31:0]            o_lat_min,
    output logic signed [31:0]            o_lat_max,
    output logic [7:0]                    o_control_word,
    output logic [15:0]                   o_point_count,
    output logic [31:0]                   o_location,
    output logic                          o_last
);
    import lldc_pkg::*;

    t_cfg   r_cfg;
    t_point front_point, queue_point;
    logic   push, full, pop, empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.base_shift <= '0;
            r_cfg.half_pi    <= HALF_PI_RESET;
            r_cfg.one        <= ONE_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_idx)
                CFG_BASE_SHIFT: r_cfg.base_shift <= i_cfg_wr_data[4:0];
                CFG_HALF_PI:    r_cfg.half_pi    <= i_cfg_wr_data[29:0];
                CFG_ONE:        r_cfg.one        <= i_cfg_wr_data[30:0];
                default: ;
            endcase
        end
    end

    lldc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_lon        (i_lon),
        .i_lat        (i_lat),
        .i_last_point (i_last_point),
        .o_push       (push),
        .o_point      (front_point),
        .i_full       (full)
    );

    lldc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_point),
        .o_full  (full),
        .i_pop   (pop),
        .o_data  (queue_point),
        .o_empty (empty)
    );

    lldc_back #(
        .MAX_SHIFT_LIMIT (MAX_SHIFT_LIMIT),
        .COUNT_BITS      (COUNT_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_point        (queue_point),
        .i_empty        (empty),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_kind         (o_kind),
        .o_dx           (o_dx),
        .o_dy           (o_dy),
        .o_lon_min      (o_lon_min),
        .o_lon_max      (o_lon_max),
        .o_lat_min      (o_lat_min),
        .o_lat_max      (o_lat_max),
        .o_control_word (o_control_word),
        .o_point_count  (o_point_count),
        .o_location     (o_location),
        .o_last         (o_last)
    );

`ifndef SYNTHESIS
    a_header_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == KIND_HEADER |-> o_last)
        else $error("header beat without last");

    a_delta_no_summary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == KIND_DELTA |-> o_point_count == 16'd0 && o_location == 32'd0)
        else $error("delta beat carries summary fields");

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !full)
        else $error("queue overrun");
`endif

endmodule
